[rtl/swst_pkg.sv]
// ----------------------------------------------------------------------------
// swst_pkg
// Shared types and constants of the sliding window statistics unit.
// ----------------------------------------------------------------------------
package swst_pkg;

  // fixed field widths
  localparam int CNT_W  = 7;
  localparam int MEAN_W = 32;
  localparam int STD_W  = 32;

  // ring depth, largest effective window; larger window sizes are clamped to it
  localparam int WINDOW_MAX = 64;

  // item kinds
  localparam logic KIND_PUSH  = 1'b0;
  localparam logic KIND_CLEAR = 1'b1;

  // sequencer states, one-hot
  typedef enum logic [13:0] {
    ST_IDLE  = 14'b00000000000001,
    ST_READ  = 14'b00000000000010,
    ST_SQ_S  = 14'b00000000000100,
    ST_ACC_S = 14'b00000000001000,
    ST_SQ_O  = 14'b00000000010000,
    ST_ACC_O = 14'b00000000100000,
    ST_SCAN  = 14'b00000001000000,
    ST_SSQ   = 14'b00000010000000,
    ST_CSQ   = 14'b00000100000000,
    ST_VNUM  = 14'b00001000000000,
    ST_DIV_V = 14'b00010000000000,
    ST_SQRT  = 14'b00100000000000,
    ST_DIV_M = 14'b01000000000000,
    ST_DONE  = 14'b10000000000000
  } state_e;

endpackage

[rtl/swst_ring.sv]
// ----------------------------------------------------------------------------
// swst_ring
// Sample ring: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module swst_ring #(
  parameter int DEPTH  = 64,
  parameter int DATA_W = 24,
  parameter int ADDR_W = 6
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

[rtl/swst_alu.sv]
// ----------------------------------------------------------------------------
// swst_alu
// Shared adder/subtractor used by every multiply, divide and root step.
// ----------------------------------------------------------------------------
module swst_alu #(
  parameter int W = 63
) (
  input  logic [W-1:0] a_i,
  input  logic [W-1:0] b_i,
  input  logic         sub_i,
  output logic [W-1:0] y_o,
  output logic         nb_o
);

  logic [W:0] sum;

  // a + b, or a - b with carry out meaning no borrow (a >= b)
  always_comb begin
    if (sub_i) begin
      sum = {1'b0, a_i} + {1'b0, ~b_i} + {{W{1'b0}}, 1'b1};
    end else begin
      sum = {1'b0, a_i} + {1'b0, b_i};
    end
  end

  assign y_o  = sum[W-1:0];
  assign nb_o = sum[W];

endmodule

[rtl/sliding_window_statistics_unit.sv]
// ----------------------------------------------------------------------------
// sliding_window_statistics_unit
// Ring of samples with running sum, sum of squares, min and max; each word
// returns mean, standard deviation, min, max, count and full flag.
// A push whose evicted sample was the min or max rescans the whole effective
// window of the ring. A clear word skips the arithmetic and goes straight to
// the result. One word at a time: the next word is accepted once the result
// is registered and the sequencer is back in idle; the single shared adder
// does every multiply, divide and square root bit step.
// Reset: empty window, window_size 64; the ring itself is not cleared.
// ----------------------------------------------------------------------------
module sliding_window_statistics_unit #(
  parameter int SAMPLE_BITS = 24
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              kind_i,
  input  logic signed [SAMPLE_BITS-1:0]     sample_value_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [swst_pkg::MEAN_W-1:0] mean_value_o,
  output logic [swst_pkg::STD_W-1:0]        std_dev_o,
  output logic signed [SAMPLE_BITS-1:0]     max_value_o,
  output logic signed [SAMPLE_BITS-1:0]     min_value_o,
  output logic [swst_pkg::CNT_W-1:0]        sample_count_o,
  output logic                              window_full_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [swst_pkg::CNT_W-1:0]        cfg_data_i
);

  localparam int S      = SAMPLE_BITS;
  localparam int CW     = swst_pkg::CNT_W;
  localparam int IDX_W  = $clog2(swst_pkg::WINDOW_MAX);
  localparam int CMP_W  = IDX_W + CW;
  localparam int SUM_W  = S + CW;
  localparam int SQ_W   = 2 * S + CW;
  localparam int CS_W   = SQ_W + CW;
  localparam int DIV_W  = CS_W + 16;
  localparam int RAD_W  = DIV_W + (DIV_W % 2);
  localparam int RT_W   = RAD_W / 2;
  localparam int ALU_W  = CS_W + 1;
  localparam int MD_W   = SUM_W + 8;
  localparam int CT_MAX = (RAD_W > 127) ? RAD_W : 127;
  localparam int CT_W   = $clog2(CT_MAX + 1);

  swst_pkg::state_e state_q, state_d;

  logic signed [S-1:0]     samp_q, samp_d, old_q, old_d;
  logic                    full_q, full_d, rescan_q, rescan_d;
  logic signed [SUM_W-1:0] sum_q, sum_d;
  logic [SQ_W-1:0]         sq_q, sq_d;
  logic signed [S-1:0]     max_q, max_d, min_q, min_d;
  logic [CW-1:0]           fill_q, fill_d, wsize_q, wsize_d;
  logic [IDX_W-1:0]        widx_q, widx_d;
  logic [ALU_W-1:0]        acc_q, acc_d, mc_q, mc_d, tmp_q, tmp_d;
  logic [RAD_W-1:0]        sh_q, sh_d;
  logic [RT_W-1:0]         res_q, res_d;
  logic [CT_W-1:0]         cnt_q, cnt_d;
  logic                    rv_q, rv_d, first_q, first_d;
  logic [swst_pkg::MEAN_W-1:0] mean_q, mean_d;
  logic [swst_pkg::STD_W-1:0]  std_q, std_d;
  logic                    out_valid_q, out_valid_d;

  logic [CW-1:0]           eff_w;
  logic                    ring_we, ring_re;
  logic [IDX_W-1:0]        ring_waddr, ring_raddr;
  logic [S-1:0]            ring_rdata;
  logic signed [S-1:0]     rd_val;
  logic [ALU_W-1:0]        alu_a, alu_b, alu_y, num;
  logic                    alu_sub, alu_nb;
  logic [S-1:0]            s_raw, o_raw, s_mag, o_mag;
  logic [SUM_W-1:0]        sum_raw, sum_mag;
  logic [2*CW-1:0]         c2;
  logic [CMP_W-1:0]        widx_inc;
  logic [MD_W-1:0]         quo;
  logic signed [MD_W:0]    quo_s;
  logic [RT_W-1:0]         res_nx;
  logic                    full_now, go_ssq, do_clear;

  // effective window size
  always_comb begin
    if (wsize_q == '0) begin
      eff_w = CW'(1);
    end else if (32'(wsize_q) > swst_pkg::WINDOW_MAX) begin
      eff_w = CW'(swst_pkg::WINDOW_MAX);
    end else begin
      eff_w = wsize_q;
    end
  end

  // magnitudes
  assign rd_val   = ring_rdata;
  assign s_raw    = samp_q;
  assign o_raw    = old_q;
  assign s_mag    = s_raw[S-1] ? (~s_raw + 1'b1) : s_raw;
  assign o_mag    = o_raw[S-1] ? (~o_raw + 1'b1) : o_raw;
  assign sum_raw  = sum_q;
  assign sum_mag  = sum_raw[SUM_W-1] ? (~sum_raw + 1'b1) : sum_raw;
  assign c2       = fill_q * fill_q;
  assign widx_inc = CMP_W'(widx_q) + CMP_W'(1);
  assign full_now = fill_q >= eff_w;
  assign num      = alu_nb ? alu_y : '0;
  assign quo      = {sh_q[MD_W-2:0], alu_nb};
  assign quo_s    = $signed({1'b0, quo});
  assign res_nx   = {res_q[RT_W-2:0], alu_nb};

  swst_ring #(
    .DEPTH  (swst_pkg::WINDOW_MAX),
    .DATA_W (S),
    .ADDR_W (IDX_W)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ring_we),
    .waddr_i (ring_waddr),
    .wdata_i (samp_q),
    .re_i    (ring_re),
    .raddr_i (ring_raddr),
    .rdata_o (ring_rdata)
  );

  swst_alu #(
    .W (ALU_W)
  ) u_alu (
    .a_i   (alu_a),
    .b_i   (alu_b),
    .sub_i (alu_sub),
    .y_o   (alu_y),
    .nb_o  (alu_nb)
  );

  assign in_ready_o  = (state_q == swst_pkg::ST_IDLE);
  assign cfg_ready_o = (state_q == swst_pkg::ST_IDLE) && !in_valid_i;

  // sequencer
  always_comb begin
    state_d     = state_q;
    samp_d      = samp_q;
    old_d       = old_q;
    full_d      = full_q;
    rescan_d    = rescan_q;
    sum_d       = sum_q;
    sq_d        = sq_q;
    max_d       = max_q;
    min_d       = min_q;
    fill_d      = fill_q;
    wsize_d     = wsize_q;
    widx_d      = widx_q;
    acc_d       = acc_q;
    mc_d        = mc_q;
    tmp_d       = tmp_q;
    sh_d        = sh_q;
    res_d       = res_q;
    cnt_d       = cnt_q;
    rv_d        = rv_q;
    first_d     = first_q;
    mean_d      = mean_q;
    std_d       = std_q;
    out_valid_d = out_valid_q && !out_ready_i;
    ring_we     = 1'b0;
    ring_re     = 1'b0;
    ring_waddr  = widx_q;
    ring_raddr  = widx_q;
    alu_a       = '0;
    alu_b       = '0;
    alu_sub     = 1'b0;
    go_ssq      = 1'b0;
    do_clear    = 1'b0;

    case (state_q)
      swst_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          if (kind_i == swst_pkg::KIND_CLEAR) begin
            do_clear = 1'b1;
            state_d  = swst_pkg::ST_DONE;
          end else begin
            samp_d  = sample_value_i;
            ring_re = 1'b1;
            state_d = swst_pkg::ST_READ;
          end
        end else if (cfg_valid_i) begin
          wsize_d  = cfg_data_i;
          do_clear = 1'b1;
        end
      end

      // oldest sample arrives, new one written, sum and min/max updated
      swst_pkg::ST_READ: begin
        old_d    = rd_val;
        ring_we  = 1'b1;
        full_d   = full_now;
        rescan_d = 1'b0;
        if (!full_now) begin
          sum_d  = sum_q + SUM_W'(samp_q);
          fill_d = fill_q + CW'(1);
          if (fill_q == '0) begin
            max_d = samp_q;
            min_d = samp_q;
          end else begin
            if (samp_q > max_q) max_d = samp_q;
            if (samp_q < min_q) min_d = samp_q;
          end
        end else begin
          sum_d = sum_q + SUM_W'(samp_q) - SUM_W'(rd_val);
          if (rd_val == max_q || rd_val == min_q) begin
            rescan_d = 1'b1;
          end else begin
            if (samp_q > max_q) max_d = samp_q;
            if (samp_q < min_q) min_d = samp_q;
          end
        end
        if (widx_inc >= CMP_W'(eff_w)) begin
          widx_d = '0;
        end else begin
          widx_d = IDX_W'(widx_inc);
        end
        acc_d   = '0;
        mc_d    = ALU_W'(s_mag);
        sh_d    = RAD_W'(s_mag) << (RAD_W - S);
        cnt_d   = CT_W'(S);
        state_d = swst_pkg::ST_SQ_S;
      end

      // shift-add multiply steps, multiplier msb first
      swst_pkg::ST_SQ_S, swst_pkg::ST_SQ_O, swst_pkg::ST_SSQ, swst_pkg::ST_CSQ: begin
        alu_a = {acc_q[ALU_W-2:0], 1'b0};
        alu_b = sh_q[RAD_W-1] ? mc_q : '0;
        acc_d = alu_y;
        sh_d  = {sh_q[RAD_W-2:0], 1'b0};
        cnt_d = cnt_q - CT_W'(1);
        if (cnt_q == CT_W'(1)) begin
          case (state_q)
            swst_pkg::ST_SQ_S: state_d = swst_pkg::ST_ACC_S;
            swst_pkg::ST_SQ_O: state_d = swst_pkg::ST_ACC_O;
            swst_pkg::ST_SSQ: begin
              tmp_d   = alu_y;
              acc_d   = '0;
              mc_d    = ALU_W'(sq_q);
              sh_d    = RAD_W'(fill_q) << (RAD_W - CW);
              cnt_d   = CT_W'(CW);
              state_d = swst_pkg::ST_CSQ;
            end
            default: state_d = swst_pkg::ST_VNUM;
          endcase
        end
      end

      // add square of the new sample
      swst_pkg::ST_ACC_S: begin
        alu_a = ALU_W'(sq_q);
        alu_b = acc_q;
        sq_d  = SQ_W'(alu_y);
        if (full_q) begin
          acc_d   = '0;
          mc_d    = ALU_W'(o_mag);
          sh_d    = RAD_W'(o_mag) << (RAD_W - S);
          cnt_d   = CT_W'(S);
          state_d = swst_pkg::ST_SQ_O;
        end else begin
          go_ssq = 1'b1;
        end
      end

      // remove square of the evicted sample
      swst_pkg::ST_ACC_O: begin
        alu_a   = ALU_W'(sq_q);
        alu_b   = acc_q;
        alu_sub = 1'b1;
        sq_d    = SQ_W'(alu_y);
        if (rescan_q) begin
          cnt_d   = '0;
          rv_d    = 1'b0;
          first_d = 1'b1;
          state_d = swst_pkg::ST_SCAN;
        end else begin
          go_ssq = 1'b1;
        end
      end

      // rescan the ring for min and max
      swst_pkg::ST_SCAN: begin
        rv_d = cnt_q < CT_W'(eff_w);
        if (cnt_q < CT_W'(eff_w)) begin
          ring_re    = 1'b1;
          ring_raddr = IDX_W'(cnt_q);
          cnt_d      = cnt_q + CT_W'(1);
        end
        if (rv_q) begin
          first_d = 1'b0;
          if (first_q) begin
            max_d = rd_val;
            min_d = rd_val;
          end else begin
            if (rd_val > max_q) max_d = rd_val;
            if (rd_val < min_q) min_d = rd_val;
          end
        end else if (!(cnt_q < CT_W'(eff_w))) begin
          go_ssq = 1'b1;
        end
      end

      // numerator of the variance, clamped at zero
      swst_pkg::ST_VNUM: begin
        alu_a   = acc_q;
        alu_b   = tmp_q;
        alu_sub = 1'b1;
        sh_d    = RAD_W'({num[CS_W-1:0], 16'b0}) << (RAD_W - DIV_W);
        acc_d   = '0;
        mc_d    = ALU_W'(c2);
        cnt_d   = CT_W'(DIV_W);
        state_d = swst_pkg::ST_DIV_V;
      end

      // restoring divide steps, quotient shifts in at the bottom
      swst_pkg::ST_DIV_V, swst_pkg::ST_DIV_M: begin
        alu_a   = {acc_q[ALU_W-2:0], sh_q[RAD_W-1]};
        alu_b   = mc_q;
        alu_sub = 1'b1;
        acc_d   = alu_nb ? alu_y : alu_a;
        sh_d    = {sh_q[RAD_W-2:0], alu_nb};
        cnt_d   = cnt_q - CT_W'(1);
        if (cnt_q == CT_W'(1)) begin
          if (state_q == swst_pkg::ST_DIV_V) begin
            acc_d   = '0;
            res_d   = '0;
            cnt_d   = CT_W'(RT_W);
            state_d = swst_pkg::ST_SQRT;
          end else begin
            mean_d  = swst_pkg::MEAN_W'(sum_q[SUM_W-1] ? -quo_s : quo_s);
            state_d = swst_pkg::ST_DONE;
          end
        end
      end

      // square root, two radicand bits a step
      swst_pkg::ST_SQRT: begin
        alu_a   = {acc_q[ALU_W-3:0], sh_q[RAD_W-1:RAD_W-2]};
        alu_b   = ALU_W'({res_q, 2'b01});
        alu_sub = 1'b1;
        acc_d   = alu_nb ? alu_y : alu_a;
        res_d   = res_nx;
        sh_d    = {sh_q[RAD_W-3:0], 2'b00};
        cnt_d   = cnt_q - CT_W'(1);
        if (cnt_q == CT_W'(1)) begin
          std_d   = swst_pkg::STD_W'(res_nx);
          acc_d   = '0;
          mc_d    = ALU_W'(fill_q);
          sh_d    = RAD_W'({sum_mag, 8'b0}) << (RAD_W - MD_W);
          cnt_d   = CT_W'(MD_W);
          state_d = swst_pkg::ST_DIV_M;
        end
      end

      // hand the result word to the output register
      swst_pkg::ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          state_d     = swst_pkg::ST_IDLE;
        end
      end

      default: state_d = swst_pkg::ST_IDLE;
    endcase

    // start the square of the sum magnitude
    if (go_ssq) begin
      acc_d   = '0;
      mc_d    = ALU_W'(sum_mag);
      sh_d    = RAD_W'(sum_mag) << (RAD_W - SUM_W);
      cnt_d   = CT_W'(SUM_W);
      state_d = swst_pkg::ST_SSQ;
    end

    // empty the window
    if (do_clear) begin
      widx_d = '0;
      fill_d = '0;
      sum_d  = '0;
      sq_d   = '0;
      max_d  = '0;
      min_d  = '0;
      mean_d = '0;
      std_d  = '0;
    end
  end

  // control and statistics state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= swst_pkg::ST_IDLE;
      wsize_q     <= CW'(64);
      widx_q      <= '0;
      fill_q      <= '0;
      sum_q       <= '0;
      sq_q        <= '0;
      max_q       <= '0;
      min_q       <= '0;
      mean_q      <= '0;
      std_q       <= '0;
      cnt_q       <= '0;
      rv_q        <= 1'b0;
      first_q     <= 1'b0;
      full_q      <= 1'b0;
      rescan_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      wsize_q     <= wsize_d;
      widx_q      <= widx_d;
      fill_q      <= fill_d;
      sum_q       <= sum_d;
      sq_q        <= sq_d;
      max_q       <= max_d;
      min_q       <= min_d;
      mean_q      <= mean_d;
      std_q       <= std_d;
      cnt_q       <= cnt_d;
      rv_q        <= rv_d;
      first_q     <= first_d;
      full_q      <= full_d;
      rescan_q    <= rescan_d;
      out_valid_q <= out_valid_d;
    end
  end

  // datapath work registers
  always_ff @(posedge clk_i) begin
    samp_q <= samp_d;
    old_q  <= old_d;
    acc_q  <= acc_d;
    mc_q   <= mc_d;
    tmp_q  <= tmp_d;
    sh_q   <= sh_d;
    res_q  <= res_d;
  end

  // output word register
  always_ff @(posedge clk_i) begin
    if (state_q == swst_pkg::ST_DONE && (!out_valid_q || out_ready_i)) begin
      mean_value_o   <= mean_q;
      std_dev_o      <= std_q;
      max_value_o    <= max_q;
      min_value_o    <= min_q;
      sample_count_o <= fill_q;
      window_full_o  <= full_now;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule
